### hw/rtl/csrd_pkg.sv
// Shared types and constants for the classless static route decoder.
// No dependencies; imported by csrd_step and the core top level.
package csrd_pkg;

  localparam int unsigned OctetW     = 8;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned PrefixW    = 6;
  localparam int unsigned CountW     = 3;
  localparam int unsigned MaxPrefix  = 32;
  localparam int unsigned HopOctets  = 4;

  typedef enum logic [1:0] {
    KindEnd     = 2'd0,
    KindRoute   = 2'd1,
    KindGateway = 2'd2,
    KindError   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [AddrW-1:0]     dest_addr;
    logic [PrefixW-1:0]   prefix_len;
    logic [AddrW-1:0]     router_addr;
    logic                 option_end;
    logic                 found_any;
  } result_t;

endpackage

### hw/rtl/csrd_step.sv
// Per-octet parser: route state registers plus the next-state and result logic.
// Depends on csrd_pkg.
module csrd_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_en_i,
  input  logic [csrd_pkg::OctetW-1:0]   octet_i,
  input  logic                          final_i,
  output logic                          has_result_o,
  output csrd_pkg::result_t             result_o
);
  import csrd_pkg::*;

  typedef enum logic [1:0] {
    PhPrefix = 2'd0,
    PhDest   = 2'd1,
    PhHop    = 2'd2,
    PhDrain  = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [PrefixW-1:0]  held_q, held_d;
  logic [CountW-1:0]   left_q, left_d;
  logic [AddrW-1:0]    dest_q, dest_d;
  logic [AddrW-1:0]    hop_q, hop_d;
  logic                seen_q, seen_d;

  logic [6:0]          pfx_round;
  logic [CountW-1:0]   held_bytes;
  logic [4:0]          align_sh;
  logic [AddrW-1:0]    dest_align;
  logic [AddrW-1:0]    dest_mask;
  logic [PrefixW-1:0]  mask_sh;
  logic [CountW-1:0]   left_dec;

  assign pfx_round  = {1'b0, octet_i[PrefixW-1:0]} + 7'd7;
  assign held_bytes = CountW'(({1'b0, held_q} + 7'd7) >> 3);
  assign align_sh   = {CountW'(HopOctets) - held_bytes, 2'b00} << 1;
  assign dest_align = dest_q << align_sh;
  assign mask_sh    = PrefixW'(MaxPrefix) - held_q;
  assign dest_mask  = {AddrW{1'b1}} << mask_sh;
  assign left_dec   = left_q - CountW'(1);

  always_comb begin
    logic fail;
    logic clear;
    fail         = 1'b0;
    clear        = 1'b0;
    phase_d      = phase_q;
    held_d       = held_q;
    left_d       = left_q;
    dest_d       = dest_q;
    hop_d        = hop_q;
    seen_d       = seen_q;
    has_result_o = 1'b0;
    result_o     = '0;
    result_o.kind = KindEnd;

    case (phase_q)
      PhPrefix: begin
        if (octet_i > OctetW'(MaxPrefix)) begin
          fail = 1'b1;
        end else begin
          held_d = octet_i[PrefixW-1:0];
          dest_d = '0;
          hop_d  = '0;
          if (octet_i == '0) begin
            phase_d = PhHop;
            left_d  = CountW'(HopOctets);
          end else begin
            phase_d = PhDest;
            left_d  = CountW'(pfx_round >> 3);
          end
          fail = final_i;
        end
      end
      PhDest: begin
        dest_d = {dest_q[AddrW-OctetW-1:0], octet_i};
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = PhHop;
          left_d  = CountW'(HopOctets);
        end
        fail = final_i;
      end
      PhHop: begin
        hop_d  = {hop_q[AddrW-OctetW-1:0], octet_i};
        left_d = left_dec;
        if (left_dec != '0) begin
          fail = final_i;
        end else begin
          has_result_o         = 1'b1;
          result_o.router_addr = hop_d;
          result_o.option_end  = final_i;
          result_o.found_any   = final_i;
          if (held_q == '0) begin
            result_o.kind = KindGateway;
          end else begin
            result_o.kind       = KindRoute;
            result_o.dest_addr  = dest_align & dest_mask;
            result_o.prefix_len = held_q;
          end
          // Start the next route; keep the found flag for this option.
          phase_d = PhPrefix;
          held_d  = '0;
          left_d  = '0;
          dest_d  = '0;
          hop_d   = '0;
          seen_d  = 1'b1;
          clear   = final_i;
        end
      end
      default: begin
        if (final_i) begin
          has_result_o        = 1'b1;
          result_o.kind       = KindEnd;
          result_o.option_end = 1'b1;
          result_o.found_any  = seen_q;
          clear               = 1'b1;
        end
      end
    endcase

    if (fail) begin
      has_result_o        = 1'b1;
      result_o            = '0;
      result_o.kind       = KindError;
      result_o.option_end = final_i;
      result_o.found_any  = final_i & seen_q;
      if (final_i) begin
        clear = 1'b1;
      end else begin
        phase_d = PhDrain;
      end
    end

    if (clear) begin
      phase_d = PhPrefix;
      held_d  = '0;
      left_d  = '0;
      dest_d  = '0;
      hop_d   = '0;
      seen_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPrefix;
      held_q  <= '0;
      left_q  <= '0;
      dest_q  <= '0;
      hop_q   <= '0;
      seen_q  <= 1'b0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      left_q  <= left_d;
      dest_q  <= dest_d;
      hop_q   <= hop_d;
      seen_q  <= seen_d;
    end
  end

endmodule

### hw/rtl/classless_static_route_decoder_core.sv
// Top level of the classless static route decoder: input register, parser, result register.
// Depends on csrd_pkg and csrd_step.
//
// The block takes the classless static route option one octet per request and
// returns one result per decoded route (kind 1), default gateway (kind 2),
// malformed option (kind 3) or closing octet after an error (kind 0). The
// parser makes a single state update per octet; with no downstream stall the
// block sustains one octet per cycle, and each request passes the input
// register and the parser before its result is held in the result register
// and presented on the result channel. An octet that yields no result
// never waits for the output side, and an octet whose result is pending stalls
// only while the result register is full and stalled. Destinations are
// left-aligned and masked to the prefix; option_end marks the result that
// closes the option, and found_any then reports whether any route was decoded.
module classless_static_route_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [csrd_pkg::OctetW-1:0]   octet_value_i,
  input  logic                          final_octet_i,
  // result channel
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [1:0]                    kind_o,
  output logic [csrd_pkg::AddrW-1:0]    dest_addr_o,
  output logic [csrd_pkg::PrefixW-1:0]  prefix_len_o,
  output logic [csrd_pkg::AddrW-1:0]    router_addr_o,
  output logic                          option_end_o,
  output logic                          found_any_o
);
  import csrd_pkg::*;

  // Input register.
  logic              in_valid_q;
  logic [OctetW-1:0] in_octet_q;
  logic              in_final_q;

  // Result register.
  logic              out_valid_q;
  result_t           out_res_q;

  logic              has_result;
  result_t           step_res;
  logic              out_free;
  logic              advance;
  logic              in_load;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !stall_i;
  // Advance the held request unless its result has nowhere to go.
  assign advance  = in_valid_q && (!has_result || out_free);
  assign in_load  = !in_valid_q || advance;
  assign stall_o  = !in_load;

  csrd_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (advance),
    .octet_i      (in_octet_q),
    .final_i      (in_final_q),
    .has_result_o (has_result),
    .result_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= valid_i;
      end
      if (advance && has_result) begin
        out_valid_q <= 1'b1;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_load && valid_i) begin
      in_octet_q <= octet_value_i;
      in_final_q <= final_octet_i;
    end
    if (advance && has_result) begin
      out_res_q <= step_res;
    end
  end

  assign valid_o       = out_valid_q;
  assign kind_o        = out_res_q.kind;
  assign dest_addr_o   = out_res_q.dest_addr;
  assign prefix_len_o  = out_res_q.prefix_len;
  assign router_addr_o = out_res_q.router_addr;
  assign option_end_o  = out_res_q.option_end;
  assign found_any_o   = out_res_q.found_any;

endmodule

### bench/tb_classless_static_route_decoder_core.sv
// Self-checking bench for classless_static_route_decoder_core: drives route option
// octets over the valid/stall request channel and checks every decoded result.
// Depends on csrd_pkg and the RTL of the core; needs no files or arguments.
module tb_classless_static_route_decoder_core;
  import csrd_pkg::*;

  typedef logic [OctetW-1:0] octet_q_t[$];

  // Parser phases of the bench's own model of the decoder.
  typedef enum logic [1:0] {
    AwaitPrefix = 2'd0,
    TakeDest    = 2'd1,
    TakeHop     = 2'd2,
    Drain       = 2'd3
  } parse_phase_e;

  localparam int unsigned WatchLimit  = 2000;
  localparam int unsigned HoldOff     = 300;
  localparam int unsigned TailCycles  = 10;
  localparam int unsigned MaxReported = 10;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic [OctetW-1:0]  octet_value_i = '0;
  logic               final_octet_i = 1'b0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic [1:0]         kind_o;
  logic [AddrW-1:0]   dest_addr_o;
  logic [PrefixW-1:0] prefix_len_o;
  logic [AddrW-1:0]   router_addr_o;
  logic               option_end_o;
  logic               found_any_o;

  classless_static_route_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .octet_value_i (octet_value_i),
    .final_octet_i (final_octet_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .kind_o        (kind_o),
    .dest_addr_o   (dest_addr_o),
    .prefix_len_o  (prefix_len_o),
    .router_addr_o (router_addr_o),
    .option_end_o  (option_end_o),
    .found_any_o   (found_any_o)
  );

  // Idle rates in percent, set per test; hold_req asks the receiver for a long stall.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;

  int unsigned octets_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned kind_count[4];

  // Results owed by the decoder, oldest first.
  result_t route_results_due[$];

  // Model state of the option parser.
  parse_phase_e       ps_phase = AwaitPrefix;
  logic [PrefixW-1:0] ps_prefix = '0;
  logic [CountW-1:0]  ps_left = '0;
  logic [AddrW-1:0]   ps_dest = '0;
  logic [AddrW-1:0]   ps_hop = '0;
  logic               ps_seen = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic clear_parse_state();
    ps_phase  = AwaitPrefix;
    ps_prefix = '0;
    ps_left   = '0;
    ps_dest   = '0;
    ps_hop    = '0;
    ps_seen   = 1'b0;
  endtask

  // Advance the parser model by one accepted octet and queue any result it owes.
  task automatic predict_route_octet(input logic [OctetW-1:0] oct, input logic fin);
    result_t          res;
    logic             owe;
    logic             bad;
    int unsigned      nbytes;
    logic [AddrW-1:0] dest;
    logic [AddrW-1:0] mask;
    res  = '0;
    owe  = 1'b0;
    bad  = 1'b0;
    dest = '0;
    case (ps_phase)
      AwaitPrefix: begin
        if (oct > MaxPrefix) begin
          bad = 1'b1;
        end else begin
          ps_prefix = oct[PrefixW-1:0];
          ps_dest   = '0;
          ps_hop    = '0;
          ps_left   = CountW'((int'(oct) + 7) / 8);
          if (ps_left == 0) begin
            ps_phase = TakeHop;
            ps_left  = CountW'(HopOctets);
          end else begin
            ps_phase = TakeDest;
          end
          // a prefix byte can never close an option cleanly
          if (fin) bad = 1'b1;
        end
      end
      TakeDest: begin
        ps_dest = {ps_dest[AddrW-OctetW-1:0], oct};
        ps_left = ps_left - 1'b1;
        if (ps_left == 0) begin
          ps_phase = TakeHop;
          ps_left  = CountW'(HopOctets);
        end
        if (fin) bad = 1'b1;
      end
      TakeHop: begin
        ps_hop  = {ps_hop[AddrW-OctetW-1:0], oct};
        ps_left = ps_left - 1'b1;
        if (ps_left != 0) begin
          if (fin) bad = 1'b1;
        end else begin
          // left-align the destination octets, then mask to the prefix
          nbytes = (int'(ps_prefix) + 7) / 8;
          if (nbytes != 0) dest = ps_dest << (8 * (4 - nbytes));
          ps_seen         = 1'b1;
          owe             = 1'b1;
          res.router_addr = ps_hop;
          res.option_end  = fin;
          res.found_any   = fin;
          if (ps_prefix == 0) begin
            res.kind = KindGateway;
          end else begin
            mask           = {AddrW{1'b1}} << (MaxPrefix - int'(ps_prefix));
            res.kind       = KindRoute;
            res.dest_addr  = dest & mask;
            res.prefix_len = ps_prefix;
          end
          if (fin) begin
            clear_parse_state();
          end else begin
            ps_phase  = AwaitPrefix;
            ps_prefix = '0;
            ps_left   = '0;
            ps_dest   = '0;
            ps_hop    = '0;
          end
        end
      end
      default: begin
        // drop everything after an error until the closing octet
        if (fin) begin
          owe            = 1'b1;
          res.kind       = KindEnd;
          res.option_end = 1'b1;
          res.found_any  = ps_seen;
          clear_parse_state();
        end
      end
    endcase
    if (bad) begin
      owe            = 1'b1;
      res            = '0;
      res.kind       = KindError;
      res.option_end = fin;
      res.found_any  = fin & ps_seen;
      if (fin) clear_parse_state();
      else ps_phase = Drain;
    end
    if (owe) route_results_due.push_back(res);
  endtask

  // Offer one octet, with random idle cycles ahead of it, and hold it until accepted.
  task automatic send_octet(input logic [OctetW-1:0] oct, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    octet_value_i <= oct;
    final_octet_i <= fin;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    predict_route_octet(oct, fin);
    octets_sent++;
  endtask

  // Send a whole option; mark only the last octet final.
  task automatic send_option(input octet_q_t q);
    for (int i = 0; i < q.size(); i++) send_octet(q[i], i == q.size() - 1);
  endtask

  task automatic add_route(ref octet_q_t q, input int unsigned pfx);
    q.push_back(OctetW'(pfx));
    repeat ((pfx + 7) / 8) q.push_back(OctetW'($urandom_range(0, 255)));
    repeat (HopOctets) q.push_back(OctetW'($urandom_range(0, 255)));
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic wait_drained();
    valid_i <= 1'b0;
    while (route_results_due.size() != 0) @(posedge clk_i);
  endtask

  // Result checker, receiver stall driver and idle-cycle count for the watchdog.
  initial begin
    result_t     want;
    result_t     got;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && valid_o && !stall_i) begin
        got.kind        = kind_e'(kind_o);
        got.dest_addr   = dest_addr_o;
        got.prefix_len  = prefix_len_o;
        got.router_addr = router_addr_o;
        got.option_end  = option_end_o;
        got.found_any   = found_any_o;
        results_seen++;
        kind_count[kind_o]++;
        if (route_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("unexpected result: kind %0d dest %h pfx %0d hop %h end %b found %b",
                     got.kind, got.dest_addr, got.prefix_len, got.router_addr,
                     got.option_end, got.found_any);
        end else begin
          want = route_results_due.pop_front();
          if (got.kind != want.kind || got.dest_addr != want.dest_addr ||
              got.prefix_len != want.prefix_len || got.router_addr != want.router_addr ||
              got.option_end != want.option_end || got.found_any != want.found_any) begin
            mismatches++;
            if (mismatches <= MaxReported) begin
              $display("mismatch at result %0d:", results_seen);
              $display("  expected kind %0d dest %h pfx %0d hop %h end %b found %b",
                       want.kind, want.dest_addr, want.prefix_len, want.router_addr,
                       want.option_end, want.found_any);
              $display("  actual   kind %0d dest %h pfx %0d hop %h end %b found %b",
                       got.kind, got.dest_addr, got.prefix_len, got.router_addr,
                       got.option_end, got.found_any);
            end
          end
        end
      end
      // restart the watchdog on any request or result moving
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
      else idle_cycles++;
      // take a pending long hold-off, else stall at the current random rate
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        stall_i <= 1'b1;
        hold_left--;
      end else begin
        stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    while (idle_cycles < WatchLimit) @(posedge clk_i);
    $display("watchdog: no request or result accepted for %0d cycles", WatchLimit);
    $display("tb_classless_static_route_decoder_core: errors");
    $finish;
  end

  // Extremes and several malformed cases, a few octets apiece.
  task automatic test_directed_cases();
    octet_q_t q;
    // full /32 route with all-ones fields, closed by its own last hop octet
    q = '{8'd32, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_option(q);
    // default gateway, then a /9 cut off inside its next hop
    q = '{8'd0, 8'h01, 8'h02, 8'h03, 8'h04, 8'd9, 8'hFF, 8'hFF, 8'h0A};
    send_option(q);
    // prefix above 32: error, ignored octet, then end-only on the closing octet
    q = '{8'd33, 8'h07, 8'hC8};
    send_option(q);
    // bad prefix on the closing octet
    q = '{8'hFF};
    send_option(q);
    // option that ends on a prefix byte
    q = '{8'd1};
    send_option(q);
  endtask

  // Random options: mostly well formed, some truncated, padded or with bad prefixes.
  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned n_octets);
    octet_q_t    q;
    int unsigned stop_at;
    int unsigned n_routes;
    int unsigned pick;
    int unsigned pfx;
    int unsigned cut;
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    stop_at        = octets_sent + n_octets;
    while (octets_sent < stop_at) begin
      q = {};
      n_routes = $urandom_range(1, 4);
      for (int r = 0; r < n_routes; r++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) pfx = 0;
        else if (pick == 1) pfx = MaxPrefix;
        else pfx = $urandom_range(1, MaxPrefix - 1);
        add_route(q, pfx);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // bad prefix after the last route, followed by garbage
        q.push_back(OctetW'($urandom_range(MaxPrefix + 1, 255)));
        repeat ($urandom_range(0, 5)) q.push_back(OctetW'($urandom_range(0, 255)));
      end else if (pick < 16) begin
        // truncate partway through
        cut = $urandom_range(1, q.size() - 1);
        while (q.size() > cut) void'(q.pop_back());
      end else if (pick < 22) begin
        // trailing random octets
        repeat ($urandom_range(1, 6)) q.push_back(OctetW'($urandom_range(0, 255)));
      end
      send_option(q);
    end
  endtask

  // Hold off the receiver for a long stretch while routes keep coming.
  task automatic test_output_holdoff();
    octet_q_t q;
    q = {};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = HoldOff;
    repeat (8) add_route(q, 0);
    send_option(q);
    wait_drained();
  endtask

  // Pause the sender until all owed results are in, then resume mid-stream.
  task automatic test_pause_for_drain();
    octet_q_t q;
    q = {};
    add_route(q, 24);
    add_route(q, 7);
    send_option(q);
    wait_drained();
    q = {};
    add_route(q, 16);
    send_option(q);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 33;
    recv_stall_pct = 78;
    test_directed_cases();
    test_random_traffic(33, 78, 110);
    test_random_traffic(78, 33, 110);
    test_output_holdoff();
    test_pause_for_drain();
    test_random_traffic(0, 0, 110);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d octets, %0d results: %0d routes, %0d gateways, %0d errors, %0d end-only",
             octets_sent, results_seen, kind_count[KindRoute], kind_count[KindGateway],
             kind_count[KindError], kind_count[KindEnd]);
    $display("idle mixes 33/78, 78/33 and none, plus a %0d-cycle output hold-off", HoldOff);
    if (mismatches == 0 && route_results_due.size() == 0) begin
      $display("tb_classless_static_route_decoder_core: clean");
    end else begin
      $display("%0d mismatches, %0d results still owed", mismatches,
               route_results_due.size());
      $display("tb_classless_static_route_decoder_core: errors");
    end
    $finish;
  end

endmodule
